### sv/cofd_pkg.sv
// ----------------------------------------------------------------------------
// Clock offset min-delay filter package
// Types and constants shared by the filter front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cofd_pkg;

	localparam int TIME_W = 63;
	localparam int OFF_W  = 64;
	localparam int RTT_W  = 16;
	localparam int BRT_W  = 17;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 6;
	localparam int CIDX_W = 8;
	localparam int CDAT_W = 32;
	localparam int IN_W   = 320;
	localparam int OUT_W  = 88;

	localparam logic [CIDX_W-1:0] CFG_MAX_RT   = 8'd0;
	localparam logic [CIDX_W-1:0] CFG_JUMP_LIM = 8'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX_AGE  = 8'd2;
	localparam logic [CIDX_W-1:0] CFG_MIN_SYNC = 8'd3;

	localparam logic [STAT_W-1:0] ST_ACCEPT     = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_ECHO   = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_TIMING = 3'd2;
	localparam logic [STAT_W-1:0] ST_JUMP_CLEAR = 3'd3;
	localparam logic [STAT_W-1:0] ST_MODE_CLEAR = 3'd4;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_REJ_ECHO,
		CMD_REJ_TIME,
		CMD_SAMPLE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [RTT_W-1:0]   rtt;
		logic [OFF_W-1:0]   off;
		logic [TIME_W-1:0]  host_time;
	} cmd_t;

	typedef struct packed {
		logic [15:0] max_rt;
		logic [19:0] jump_lim;
		logic [31:0] max_age;
		logic [5:0]  min_sync;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECIDE,
		BK_EV_RD,
		BK_EV_CHK,
		BK_SCAN,
		BK_FINISH,
		BK_OUT
	} bk_state_t;

endpackage

`default_nettype wire

### sv/cofd_front.sv
// ----------------------------------------------------------------------------
// Filter front end
// Two-stage classifier: validates a reply and forms round trip and offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cofd_front
	import cofd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_mode,
	input  wire logic [IN_W-1:0]   in_data,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output cmd_t                   cmd
);

	logic [TIME_W-1:0] t1, echo, t2, t3, t4;
	logic              adv1, adv2;
	logic              v_s1, v_s2;
	cmd_kind_t         kind_s1;
	logic [TIME_W-1:0] d1_s1, d2_s1, t4_s1;
	logic [OFF_W-1:0]  a_s1, b_s1;
	cmd_t              cmd_s2, cmd_n;
	logic [TIME_W-1:0] rtt;
	logic [OFF_W:0]    sum;
	cmd_kind_t         kind_e;

	assign t1   = in_data[62:0];
	assign echo = in_data[125:63];
	assign t2   = in_data[188:126];
	assign t3   = in_data[251:189];
	assign t4   = in_data[314:252];

	assign adv2     = !v_s2 || cmd_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	always_comb begin
		if (in_mode)
			kind_e = CMD_CLEAR;
		else if (t1 == '0 || echo != t1)
			kind_e = CMD_REJ_ECHO;
		else if (t3 < t2 || t4 < t1)
			kind_e = CMD_REJ_TIME;
		else
			kind_e = CMD_SAMPLE;
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			kind_s1 <= kind_e;
			d1_s1   <= t4 - t1;
			d2_s1   <= t3 - t2;
			a_s1    <= {1'b0, t1} - {1'b0, t2};
			b_s1    <= {1'b0, t4} - {1'b0, t3};
			t4_s1   <= t4;
		end
	end

	assign rtt = d1_s1 - d2_s1;
	assign sum = {a_s1[OFF_W-1], a_s1} + {b_s1[OFF_W-1], b_s1};

	always_comb begin
		cmd_n.kind      = kind_s1;
		cmd_n.rtt       = rtt[RTT_W-1:0];
		cmd_n.host_time = t4_s1;
		if (sum[OFF_W] != sum[OFF_W-1])
			cmd_n.off = sum[OFF_W] ? {1'b1, {(OFF_W-1){1'b0}}} : {1'b0, {(OFF_W-1){1'b1}}};
		else
			cmd_n.off = sum[OFF_W-1:0];
		if (kind_s1 == CMD_SAMPLE &&
			(d1_s1 < d2_s1 || rtt > {{(TIME_W-16){1'b0}}, cfg.max_rt}))
			cmd_n.kind = CMD_REJ_TIME;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1)
			cmd_s2 <= cmd_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	assign cmd_valid = v_s2;
	assign cmd       = cmd_s2;

endmodule

`default_nettype wire

### sv/cofd_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cofd_queue
	import cofd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_valid,
	output logic      wr_ready,
	input  wire cmd_t wr_cmd,
	output logic      rd_valid,
	input  wire logic rd_pop,
	output cmd_t      rd_cmd
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

`default_nettype wire

### sv/cofd_back.sv
// ----------------------------------------------------------------------------
// Filter back end
// Window update, jump and mode clears, age eviction and minimum round-trip scan over the window.
// ----------------------------------------------------------------------------
`default_nettype none

module cofd_back
	import cofd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               cmd_valid,
	output logic                    cmd_pop,
	input  wire cmd_t               cmd,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [STAT_W-1:0]       res_status,
	output logic [OUT_W-1:0]        res_data
);

	localparam int IW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(WINDOW_DEPTH - 1);
	localparam logic [IW:0]   DEP  = (IW + 1)'(WINDOW_DEPTH);

	logic [TIME_W-1:0] host_mem [WINDOW_DEPTH];
	logic [OFF_W-1:0]  off_mem  [WINDOW_DEPTH];
	logic [RTT_W-1:0]  rtt_mem  [WINDOW_DEPTH];

	bk_state_t         state_q, state_n;
	cmd_t              cmd_q;
	logic [IW-1:0]     head_q;
	logic [CW-1:0]     count_q, idx_q;
	logic [OFF_W-1:0]  best_off_q, run_off_q, off_rd_q;
	logic [BRT_W-1:0]  best_rt_q;
	logic [RTT_W-1:0]  run_rt_q, rtt_rd_q;
	logic [TIME_W-1:0] host_rd_q;
	logic              sync_q, pend_q, first_q;
	logic [STAT_W-1:0] status_q;

	logic              rd_en, jump, evict, full, scan_rd;
	logic [IW-1:0]     rd_addr, pos, head_inc;
	logic [IW:0]       sum_hc, sum_hi;
	logic [OFF_W:0]    diff;
	logic [OFF_W:0]    adiff;
	logic [TIME_W-1:0] age;

	assign full     = 32'(count_q) >= 32'(WINDOW_DEPTH);
	assign head_inc = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign sum_hc   = (IW + 1)'(head_q) + (IW + 1)'(count_q);
	assign sum_hi   = (IW + 1)'(head_q) + (IW + 1)'(idx_q);
	assign pos      = full ? head_q :
		(sum_hc >= DEP ? IW'(sum_hc - DEP) : sum_hc[IW-1:0]);

	assign diff  = {cmd_q.off[OFF_W-1], cmd_q.off} - {best_off_q[OFF_W-1], best_off_q};
	assign adiff = diff[OFF_W] ? -diff : diff;
	assign jump  = sync_q && (adiff > {{(OFF_W - 20){1'b0}}, cfg.jump_lim, 1'b0});

	assign age   = cmd_q.host_time - host_rd_q;
	assign evict = cmd_q.host_time > host_rd_q &&
		age > {{(TIME_W - 32){1'b0}}, cfg.max_age};

	assign scan_rd = 32'(idx_q) < 32'(count_q);

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE:   if (cmd_valid) state_n = BK_DECIDE;
			BK_DECIDE: state_n = (cmd_q.kind == CMD_SAMPLE && !jump) ? BK_EV_RD : BK_OUT;
			BK_EV_RD:  state_n = (count_q == '0) ? BK_SCAN : BK_EV_CHK;
			BK_EV_CHK: state_n = evict ? BK_EV_RD : BK_SCAN;
			BK_SCAN:   if (!scan_rd && !pend_q) state_n = BK_FINISH;
			BK_FINISH: state_n = BK_OUT;
			BK_OUT:    if (res_ready) state_n = BK_IDLE;
			default:   state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		res_valid = 1'b0;
		unique case (state_q)
			BK_IDLE:  cmd_pop = cmd_valid;
			BK_EV_RD: rd_en = count_q != '0;
			BK_SCAN: begin
				rd_en   = scan_rd;
				rd_addr = sum_hi >= DEP ? IW'(sum_hi - DEP) : sum_hi[IW-1:0];
			end
			BK_OUT:   res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_DECIDE && cmd_q.kind == CMD_SAMPLE && !jump) begin
			host_mem[pos] <= cmd_q.host_time;
			off_mem[pos]  <= cmd_q.off;
			rtt_mem[pos]  <= cmd_q.rtt;
		end
		if (rd_en) begin
			host_rd_q <= host_mem[rd_addr];
			off_rd_q  <= off_mem[rd_addr];
			rtt_rd_q  <= rtt_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE)
			cmd_q <= cmd;
		if (state_q == BK_SCAN && pend_q && (first_q || rtt_rd_q < run_rt_q)) begin
			run_rt_q  <= rtt_rd_q;
			run_off_q <= off_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			best_off_q <= '0;
			best_rt_q  <= '1;
			sync_q     <= 1'b0;
			status_q   <= ST_ACCEPT;
			idx_q      <= '0;
			pend_q     <= 1'b0;
			first_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			case (state_q)
				BK_DECIDE: begin
					case (cmd_q.kind)
						CMD_REJ_ECHO: status_q <= ST_BAD_ECHO;
						CMD_REJ_TIME: status_q <= ST_BAD_TIMING;
						default: begin
							if (cmd_q.kind == CMD_CLEAR || jump) begin
								head_q     <= '0;
								count_q    <= '0;
								best_off_q <= '0;
								best_rt_q  <= '1;
								sync_q     <= 1'b0;
								status_q   <= (cmd_q.kind == CMD_CLEAR) ? ST_MODE_CLEAR
									: ST_JUMP_CLEAR;
							end else begin
								status_q <= ST_ACCEPT;
								if (full)
									head_q <= head_inc;
								else
									count_q <= count_q + 1'b1;
							end
						end
					endcase
				end
				BK_EV_CHK: begin
					if (evict) begin
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end else begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						first_q <= 1'b1;
					end
				end
				BK_EV_RD: begin
					if (count_q == '0) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						first_q <= 1'b1;
					end
				end
				BK_SCAN: begin
					pend_q <= scan_rd;
					if (scan_rd)
						idx_q <= idx_q + 1'b1;
					if (pend_q)
						first_q <= 1'b0;
				end
				BK_FINISH: begin
					if (!first_q) begin
						best_off_q <= run_off_q;
						best_rt_q  <= {1'b0, run_rt_q};
					end else begin
						best_off_q <= '0;
						best_rt_q  <= '1;
					end
					sync_q <= 32'(count_q) >= 32'(cfg.min_sync);
				end
				default: ;
			endcase
		end
	end

	assign res_status = status_q;
	assign res_data   = {CNT_W'(count_q), sync_q, best_rt_q, best_off_q};

endmodule

`default_nettype wire

### sv/clock_offset_min_delay_filter.sv
// A sample passes the front end and the queue; the back end then decides, evicts entries
// older than max_age, scans the window for the minimum round trip and presents the result.
// Rejects, clears and offset jumps go from the decision to the result. The scan reads one
// window entry per cycle from the window memory. The back end takes one item at a time;
// the front end and a two-entry queue take further items meanwhile. Reset (arst_n low)
// empties the window and loads the register defaults; the window memory is not cleared.
// ----------------------------------------------------------------------------
// Clock offset min-delay filter
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_offset_min_delay_filter
	import cofd_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [CDAT_W-1:0] cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// sent_time, echoed_time, device_rx_time, device_tx_time, host_rx_time
	input  wire logic [IN_W-1:0]   s_tdata,
	// mode
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// best_offset_half_us, best_round_trip_us, synchronized, sample_count
	output logic [OUT_W-1:0]       m_tdata,
	// status
	output logic [STAT_W-1:0]      m_tuser
);

	cfg_t cfg_q;
	cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_rt   <= 16'd20000;
			cfg_q.jump_lim <= 20'd20000;
			cfg_q.max_age  <= 32'd10000000;
			cfg_q.min_sync <= 6'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAX_RT:   cfg_q.max_rt   <= cfg_data[15:0];
				CFG_JUMP_LIM: cfg_q.jump_lim <= cfg_data[19:0];
				CFG_MAX_AGE:  cfg_q.max_age  <= cfg_data;
				CFG_MIN_SYNC: cfg_q.min_sync <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	cofd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_data   (s_tdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	cofd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_cmd   (q_cmd)
	);

	cofd_back #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (q_valid),
		.cmd_pop    (q_pop),
		.cmd        (q_cmd),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_status (m_tuser),
		.res_data   (m_tdata)
	);

endmodule

`default_nettype wire

### sv/cofd_checker.sv
// ----------------------------------------------------------------------------
// Filter port checker
// Port-level properties of the filter results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cofd_checker
	import cofd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_W-1:0]  m_tdata,
	input wire logic [STAT_W-1:0] m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[87:82] == 6'd0) == (m_tdata[80:64] == 17'h1FFFF)))
		else $error("empty window and round trip disagree");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_MODE_CLEAR || m_tuser == ST_JUMP_CLEAR)
		|-> m_tdata[87:82] == 6'd0 && m_tdata[63:0] == 64'd0 && !m_tdata[81])
		else $error("clear left window state");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_ACCEPT |-> m_tdata[87:82] != 6'd0)
		else $error("accepted sample with empty window");

endmodule

bind clock_offset_min_delay_filter cofd_checker u_cofd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
